[rtl/gwwp_pkg.sv]
`default_nettype none
package gwwp_pkg;

	localparam int POS_W   = 13;
	localparam int ADDR_W  = 12;
	localparam int LL_W    = 8;
	localparam int SIZE_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 12;
	localparam int OUT_W   = 40;
	localparam int MOD_N   = POS_W;
	localparam int CNT_W   = 4;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam logic REG_LINE_LENGTH = 1'b0;
	localparam logic REG_OUT_SIZE    = 1'b1;

	localparam logic KIND_CHAR   = 1'b0;
	localparam logic KIND_LENGTH = 1'b1;

	localparam logic [LL_W-1:0]   LL_RESET   = 8'd80;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MOD1,
		ST_JUMP,
		ST_FIT,
		ST_EMIT_RD,
		ST_EMIT_WR,
		ST_ADV,
		ST_MST2,
		ST_MOD2,
		ST_GAP,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic latch;
		logic restart;
		logic consume;
		logic mod_start;
		logic jump;
		logic advance;
		logic set_gap;
		logic wl_clr;
		logic set_done;
		logic idx_clr;
		logic idx_inc;
		logic push_char;
		logic push_rep;
		logic run_last;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic first;
		logic term;
		logic space;
		logic wl_zero;
		logic full_next;
		logic eoi;
		logic mod_done;
		logic fits;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/gwwp_ram.sv]
`default_nettype none
module gwwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/gwwp_ctrl.sv]
`default_nettype none
module gwwp_ctrl
	import gwwp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   ended_q, ended_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ended_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ended_q <= ended_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ended_d  = ended_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.done) begin
					cmd.restart = sts.eoi;
					state_d     = ST_IDLE;
				end else if (!sts.first && (sts.term || sts.space) && !sts.wl_zero) begin
					cmd.mod_start = 1'b1;
					ended_d       = sts.term || sts.eoi;
					state_d       = ST_MOD1;
				end else if (!sts.first && sts.term) begin
					ended_d = 1'b1;
					state_d = ST_REPORT;
				end else begin
					cmd.consume = 1'b1;
					if (sts.eoi || sts.full_next) begin
						ended_d = 1'b1;
						if (!sts.wl_zero || (!sts.space && !sts.term)) begin
							cmd.mod_start = 1'b1;
							state_d       = ST_MOD1;
						end else begin
							state_d = ST_REPORT;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MOD1: begin
				if (sts.mod_done) begin
					state_d = ST_JUMP;
				end
			end
			ST_JUMP: begin
				cmd.jump = 1'b1;
				state_d  = ST_FIT;
			end
			ST_FIT: begin
				cmd.idx_clr = 1'b1;
				if (sts.fits) begin
					state_d = ST_EMIT_RD;
				end else begin
					cmd.wl_clr = 1'b1;
					ended_d    = 1'b1;
					state_d    = ST_REPORT;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.push_char = 1'b1;
					cmd.run_last  = !ended_q && sts.idx_last;
					if (sts.idx_last) begin
						state_d = ST_ADV;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_EMIT_RD;
					end
				end
			end
			ST_ADV: begin
				cmd.advance = 1'b1;
				state_d     = ST_MST2;
			end
			ST_MST2: begin
				cmd.mod_start = 1'b1;
				state_d       = ST_MOD2;
			end
			ST_MOD2: begin
				if (sts.mod_done) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				cmd.set_gap = 1'b1;
				cmd.wl_clr  = 1'b1;
				state_d     = ended_q ? ST_REPORT : ST_IDLE;
			end
			ST_REPORT: begin
				if (sts.out_free) begin
					cmd.push_rep = 1'b1;
					cmd.run_last = 1'b1;
					cmd.restart  = sts.eoi;
					cmd.set_done = !sts.eoi;
					ended_d      = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/gwwp_dp.sv]
`default_nettype none
module gwwp_dp
	import gwwp_pkg::*;
#(
	parameter int WORD_MAX      = 32,
	parameter int OUT_ADDR_BITS = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              in_last,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OUT_W-1:0]       out_data,
	output logic                   out_kind,
	output logic                   out_last
);

	localparam int WL_W = $clog2(WORD_MAX + 1);
	localparam int AW   = $clog2(WORD_MAX);
	localparam int CW   = WL_W + 1;
	localparam logic [POS_W-1:0] ADDR_MASK = POS_W'((64'd1 << OUT_ADDR_BITS) - 64'd1);

	logic [LL_W-1:0]   ll_q;
	logic [SIZE_W-1:0] size_q;
	logic [BYTE_W-1:0] byte_q;
	logic              eoi_q;
	logic [WL_W-1:0]   wl_q;
	logic [POS_W-1:0]  pos_q;
	logic              gap_q;
	logic              first_q;
	logic              done_q;
	logic [LL_W-1:0]   rem_q;
	logic [POS_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     idx_q;
	logic              ov_q;
	logic              okind_q;
	logic              olast_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [BYTE_W-1:0] odata_q;
	logic [POS_W-1:0]  olen_q;

	logic [LL_W-1:0]    ll_eff;
	logic [LL_W:0]      trial;
	logic [LL_W:0]      room;
	logic [POS_W-1:0]   need;
	logic [POS_W:0]     end_pos;
	logic [POS_W-1:0]   addr_full;
	logic               is_term;
	logic               is_space;
	logic               storeable;
	logic               out_free;
	logic [BYTE_W-1:0]  rd_byte;

	assign ll_eff    = (ll_q == '0) ? LL_W'(1) : ll_q;
	assign trial     = {rem_q, dvd_q[POS_W-1]};
	assign room      = {1'b0, ll_eff} - {1'b0, rem_q};
	assign need      = POS_W'(wl_q) + POS_W'(gap_q);
	assign end_pos   = (POS_W+1)'(pos_q) + (POS_W+1)'(gap_q) + (POS_W+1)'(wl_q);
	assign addr_full = (pos_q + POS_W'(gap_q) + POS_W'(idx_q)) & ADDR_MASK;
	assign is_term   = (byte_q == CH_NUL) || (byte_q == CH_CR) || (byte_q == CH_LF);
	assign is_space  = (byte_q == CH_SPACE);
	assign storeable = !is_term && !is_space;
	assign out_free  = !ov_q || out_ready;

	always_comb begin
		sts           = '0;
		sts.done      = done_q;
		sts.first     = first_q;
		sts.term      = is_term;
		sts.space     = is_space;
		sts.wl_zero   = (wl_q == '0);
		sts.full_next = storeable && (CW'(wl_q) + CW'(1) == CW'(WORD_MAX));
		sts.eoi       = eoi_q;
		sts.mod_done  = (cnt_q == '0);
		sts.fits      = end_pos <= (POS_W+1)'(size_q);
		sts.idx_last  = (CW'(idx_q) + CW'(1) == CW'(wl_q));
		sts.out_free  = out_free;
	end

	gwwp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WORD_MAX)
	) u_word_ram (
		.clk  (clk),
		.we   (cmd.consume && storeable),
		.waddr(wl_q[AW-1:0]),
		.wdata(byte_q),
		.raddr(idx_q),
		.rdata(rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ll_q   <= LL_RESET;
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_LENGTH: ll_q   <= cfg_data[LL_W-1:0];
				REG_OUT_SIZE:    size_q <= cfg_data[SIZE_W-1:0];
				default:         ll_q   <= ll_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_byte;
			eoi_q  <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= '0;
			pos_q   <= '0;
			gap_q   <= 1'b0;
			first_q <= 1'b1;
			done_q  <= 1'b0;
		end else if (cmd.restart) begin
			wl_q    <= '0;
			pos_q   <= '0;
			gap_q   <= 1'b0;
			first_q <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			if (cmd.consume) begin
				first_q <= 1'b0;
				if (storeable) begin
					wl_q <= wl_q + WL_W'(1);
				end
			end
			if (cmd.jump && (need > POS_W'(room))) begin
				pos_q <= pos_q + POS_W'(room);
				gap_q <= 1'b0;
			end
			if (cmd.advance) begin
				pos_q <= end_pos[POS_W-1:0];
			end
			if (cmd.set_gap) begin
				gap_q <= (rem_q != '0);
			end
			if (cmd.wl_clr) begin
				wl_q <= '0;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mod_start) begin
			cnt_q <= CNT_W'(MOD_N);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			rem_q <= '0;
			dvd_q <= pos_q;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, ll_eff}) begin
				rem_q <= LL_W'(trial - {1'b0, ll_eff});
			end else begin
				rem_q <= trial[LL_W-1:0];
			end
			dvd_q <= {dvd_q[POS_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.push_char || cmd.push_rep) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_char) begin
			okind_q <= KIND_CHAR;
			oaddr_q <= addr_full[ADDR_W-1:0];
			odata_q <= rd_byte;
			olen_q  <= '0;
			olast_q <= cmd.run_last;
		end else if (cmd.push_rep) begin
			okind_q <= KIND_LENGTH;
			oaddr_q <= '0;
			odata_q <= '0;
			olen_q  <= pos_q;
			olast_q <= cmd.run_last;
		end
	end

	assign out_valid = ov_q;
	assign out_kind  = okind_q;
	assign out_last  = olast_q;
	assign out_data  = {(OUT_W-POS_W-BYTE_W-ADDR_W)'(0), olen_q, odata_q, oaddr_q};

endmodule
`default_nettype wire

[rtl/greedy_word_wrap_placer.sv]
// A byte that does not finish a word passes the decide state before the next ready.
// Placing a finished word that fits takes two 13-step remainder passes over the output
// position, one word store read per emitted character, and bookkeeping.
// A fitting word's first character is output after a remainder pass and the fit check.
// Reset is asynchronous and active low; it clears all control state and sets
// line_length to 80 and out_size to 256. The word store is not cleared.
`default_nettype none
module greedy_word_wrap_placer
	import gwwp_pkg::*;
#(
	parameter int WORD_MAX      = 32,
	parameter int OUT_ADDR_BITS = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,  // text_byte
	input  wire logic              s_axis_tlast,  // end_of_input
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [OUT_W-1:0]       m_axis_tdata,  // write_addr, write_data, text_length
	output logic                   m_axis_tuser,  // kind
	output logic                   m_axis_tlast   // run_last
);

	cmd_t cmd;
	sts_t sts;

	gwwp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gwwp_dp #(
		.WORD_MAX     (WORD_MAX),
		.OUT_ADDR_BITS(OUT_ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_kind (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule
`default_nettype wire
